### hdl/krsc_pkg.sv
// Shared types and constants for the keyed record stream counter.
package krsc_pkg;

    localparam int unsigned SizeBytes = 6;

    localparam logic [15:0] KEY_LENGTH_RESET = 16'd32;

    localparam logic [1:0] EV_DATA   = 2'd0;
    localparam logic [1:0] EV_SPILL  = 2'd1;
    localparam logic [1:0] EV_TOTALS = 2'd2;

    // Register index of key_length on the configuration port.
    localparam logic REG_KEY_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        PH_SIZE       = 3'd0,
        PH_BUCKET_LO  = 3'd1,
        PH_BUCKET_HI  = 3'd2,
        PH_SKIP_DATA  = 3'd3,
        PH_SKIP_SPILL = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [47:0] record_size;
        logic [47:0] key_total;
        logic [47:0] spill_total;
        logic [62:0] payload_total;
        logic        truncated;
        logic [62:0] scanned_bytes;
        logic        last_of_run;
    } result_t;

    // Results caused by one byte: first always, second only when two is set.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } pair_t;

    typedef struct packed {
        logic  valid;
        pair_t pair;
    } run_t;

endpackage

### hdl/krsc_cfg.sv
// APB register holding key_length.
module krsc_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] key_length
);

    logic [15:0] key_length_reg;
    logic [15:0] key_length_next;
    logic        sel_key;

    assign sel_key = (paddr[2] == krsc_pkg::REG_KEY_LENGTH);
    assign pready  = 1'b1;

    always_comb
    begin
        key_length_next = key_length_reg;
        if (psel && penable && pwrite && sel_key)
        begin
            key_length_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= krsc_pkg::KEY_LENGTH_RESET;
        end
        else
        begin
            key_length_reg <= key_length_next;
        end
    end

    assign prdata     = sel_key ? {16'd0, key_length_reg} : 32'd0;
    assign key_length = key_length_reg;

endmodule

### hdl/krsc_scan.sv
// Record parser: scan state, counters and per-byte result generation.
module krsc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  krsc_pkg::in_beat_t beat,
    input  logic [15:0]        key_length,
    output krsc_pkg::run_t     run
);

    krsc_pkg::phase_t phase_reg;
    krsc_pkg::phase_t phase_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [47:0] acc_reg;
    logic [47:0] acc_next;
    logic [48:0] skip_reg;
    logic [48:0] skip_next;
    logic [7:0]  low_reg;
    logic [7:0]  low_next;
    logic [47:0] key_cnt_reg;
    logic [47:0] key_cnt_next;
    logic [47:0] spill_cnt_reg;
    logic [47:0] spill_cnt_next;
    logic [62:0] payload_reg;
    logic [62:0] payload_next;
    logic [62:0] stop_reg;
    logic [62:0] stop_next;
    logic [62:0] pos_reg;
    logic [62:0] pos_next;

    logic [62:0] pos;
    logic [47:0] acc_shift;
    logic [15:0] bucket_len;
    logic [48:0] skip_dec;
    logic        size_end;
    logic        done;
    logic [1:0]  rec_kind;
    logic        trunc;
    krsc_pkg::result_t rec_res;
    krsc_pkg::result_t tot_res;

    assign pos        = pos_reg + 63'd1;
    assign acc_shift  = {acc_reg[39:0], beat.data_byte};
    assign bucket_len = {beat.data_byte, low_reg};
    assign skip_dec   = (skip_reg != 49'd0) ? skip_reg - 49'd1 : skip_reg;
    assign size_end   = (idx_reg >= 3'(krsc_pkg::SizeBytes - 1));

    // Next phase and record completion.
    always_comb
    begin
        phase_next = phase_reg;
        done       = 1'b0;
        rec_kind   = krsc_pkg::EV_DATA;
        case (phase_reg)
            krsc_pkg::PH_BUCKET_LO:
            begin
                phase_next = krsc_pkg::PH_BUCKET_HI;
            end
            krsc_pkg::PH_BUCKET_HI:
            begin
                if (bucket_len == 16'd0)
                begin
                    done       = 1'b1;
                    rec_kind   = krsc_pkg::EV_SPILL;
                    phase_next = krsc_pkg::PH_SIZE;
                end
                else
                begin
                    phase_next = krsc_pkg::PH_SKIP_SPILL;
                end
            end
            krsc_pkg::PH_SKIP_DATA,
            krsc_pkg::PH_SKIP_SPILL:
            begin
                if (skip_dec == 49'd0)
                begin
                    done       = 1'b1;
                    rec_kind   = (phase_reg == krsc_pkg::PH_SKIP_DATA) ?
                                 krsc_pkg::EV_DATA : krsc_pkg::EV_SPILL;
                    phase_next = krsc_pkg::PH_SIZE;
                end
            end
            default:
            begin
                phase_next = krsc_pkg::PH_SIZE;
                if (size_end)
                begin
                    phase_next = (acc_shift != 48'd0) ? krsc_pkg::PH_SKIP_DATA
                                                      : krsc_pkg::PH_BUCKET_LO;
                end
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        skip_next      = skip_reg;
        low_next       = low_reg;
        key_cnt_next   = key_cnt_reg;
        spill_cnt_next = spill_cnt_reg;
        payload_next   = payload_reg;
        stop_next      = stop_reg;
        pos_next       = pos;
        case (phase_reg)
            krsc_pkg::PH_BUCKET_LO:
            begin
                low_next = beat.data_byte;
            end
            krsc_pkg::PH_BUCKET_HI:
            begin
                acc_next  = {32'd0, bucket_len};
                stop_next = pos;
                if (bucket_len == 16'd0)
                begin
                    spill_cnt_next = spill_cnt_reg + 48'd1;
                end
                else
                begin
                    skip_next = {33'd0, bucket_len};
                end
            end
            krsc_pkg::PH_SKIP_DATA,
            krsc_pkg::PH_SKIP_SPILL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 49'd0)
                begin
                    stop_next = pos;
                    if (phase_reg == krsc_pkg::PH_SKIP_DATA)
                    begin
                        key_cnt_next = key_cnt_reg + 48'd1;
                        payload_next = payload_reg + {15'd0, acc_reg};
                    end
                    else
                    begin
                        spill_cnt_next = spill_cnt_reg + 48'd1;
                    end
                end
            end
            default:
            begin
                acc_next = acc_shift;
                idx_next = idx_reg + 3'd1;
                if (size_end)
                begin
                    idx_next  = 3'd0;
                    stop_next = pos;
                    if (acc_shift != 48'd0)
                    begin
                        skip_next = {33'd0, key_length} + {1'b0, acc_shift};
                    end
                end
            end
        endcase
    end

    // Results for this byte, built from the updated counters.
    always_comb
    begin
        trunc = (phase_next != krsc_pkg::PH_SIZE);

        rec_res.event_kind    = rec_kind;
        rec_res.record_size   = acc_next;
        rec_res.key_total     = key_cnt_next;
        rec_res.spill_total   = spill_cnt_next;
        rec_res.payload_total = payload_next;
        rec_res.truncated     = 1'b0;
        rec_res.scanned_bytes = stop_next;
        rec_res.last_of_run   = !beat.final_byte;

        tot_res               = rec_res;
        tot_res.event_kind    = krsc_pkg::EV_TOTALS;
        tot_res.record_size   = 48'd0;
        tot_res.truncated     = trunc;
        tot_res.last_of_run   = 1'b1;

        run.valid       = take && (done || beat.final_byte);
        run.pair.two    = done && beat.final_byte;
        run.pair.first  = done ? rec_res : tot_res;
        run.pair.second = tot_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= krsc_pkg::PH_SIZE;
            idx_reg       <= 3'd0;
            acc_reg       <= 48'd0;
            skip_reg      <= 49'd0;
            low_reg       <= 8'd0;
            key_cnt_reg   <= 48'd0;
            spill_cnt_reg <= 48'd0;
            payload_reg   <= 63'd0;
            stop_reg      <= 63'd0;
            pos_reg       <= 63'd0;
        end
        else if (take)
        begin
            if (beat.final_byte)
            begin
                // end of file: next byte starts a fresh scan
                phase_reg     <= krsc_pkg::PH_SIZE;
                idx_reg       <= 3'd0;
                acc_reg       <= 48'd0;
                skip_reg      <= 49'd0;
                low_reg       <= 8'd0;
                key_cnt_reg   <= 48'd0;
                spill_cnt_reg <= 48'd0;
                payload_reg   <= 63'd0;
                stop_reg      <= 63'd0;
                pos_reg       <= 63'd0;
            end
            else
            begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                acc_reg       <= acc_next;
                skip_reg      <= skip_next;
                low_reg       <= low_next;
                key_cnt_reg   <= key_cnt_next;
                spill_cnt_reg <= spill_cnt_next;
                payload_reg   <= payload_next;
                stop_reg      <= stop_next;
                pos_reg       <= pos_next;
            end
        end
    end

endmodule

### hdl/krsc_obuf.sv
// Two-entry result buffer; each entry holds the one or two results of a byte.
module krsc_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  krsc_pkg::run_t    run,
    output logic              full,
    output logic              result_valid,
    input  logic              result_stall,
    output krsc_pkg::result_t result_beat
);

    krsc_pkg::pair_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       sub_reg;
    logic       sub_next;

    krsc_pkg::pair_t head;
    logic pop_beat;
    logic pop_entry;

    assign head         = entry_reg[rd_ptr_reg];
    assign full         = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result_beat  = sub_reg ? head.second : head.first;
    assign pop_beat     = result_valid && !result_stall;
    assign pop_entry    = pop_beat && (sub_reg || !head.two);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (run.valid)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop_entry)
        begin
            rd_ptr_next = !rd_ptr_reg;
            sub_next    = 1'b0;
        end
        else if (pop_beat)
        begin
            sub_next = 1'b1;
        end
        case ({run.valid, pop_entry})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (run.valid)
        begin
            entry_reg[wr_ptr_reg] <= run.pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

### hdl/keyed_record_stream_counter.sv
// A result is registered into the output buffer when the byte that causes it is taken.
// Throughput: one byte per cycle; a byte that ends a record on the final byte gives
// two result beats, and the byte input stalls while both buffer entries are held.
// The record parser registers its scan state as each byte is taken; the output buffer holds two bytes' results.
// Reset: scan state and all counters clear at once, key_length returns to 32.
module keyed_record_stream_counter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  krsc_pkg::in_beat_t byte_beat,
    output logic               result_valid,
    input  logic               result_stall,
    output krsc_pkg::result_t  result_beat,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic           take;
    logic           buf_full;
    logic [15:0]    key_length;
    krsc_pkg::run_t run;

    assign byte_stall = buf_full;
    assign take       = byte_valid && !buf_full;

    krsc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .key_length (key_length)
    );

    krsc_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .beat       (byte_beat),
        .key_length (key_length),
        .run        (run)
    );

    krsc_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .run          (run),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    // a final byte always produces at least the totals result
    a_final_runs: assert property (@(posedge clk) disable iff (!rst_n)
        take && byte_beat.final_byte |-> run.valid)
        else $error("final byte produced no results");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        run.valid && run.pair.two |->
            run.pair.second.event_kind == krsc_pkg::EV_TOTALS
            && run.pair.first.event_kind != krsc_pkg::EV_TOTALS)
        else $error("record and totals results out of order");

    a_totals_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.event_kind == krsc_pkg::EV_TOTALS |->
            result_beat.last_of_run && result_beat.record_size == 48'd0)
        else $error("malformed totals result");

    a_record_untrunc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.event_kind != krsc_pkg::EV_TOTALS |->
            !result_beat.truncated)
        else $error("record result flagged truncated");

endmodule
